// ===== sv/assert_macros.svh =====
// Assertion shorthands for the heap build block.
// Relies on clock and reset signals in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every edge outside reset.
`define MHB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication.
`define MHB_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MHB_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/mhb_pkg.sv =====
// Shared types and the microcode table for the min-heap build block.
// No dependencies; used by the sequencer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mhb_pkg;

   // Result field widths fixed by the channel format
   localparam int INDEX_W = 6;
   localparam int TOTAL_W = 6;

   localparam logic [TOTAL_W-1:0] SWAP_MAX = 6'd63;

   // Result kinds
   localparam logic KIND_SWAP    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [3:0] {
      STEP_LOAD   = 4'd0,
      STEP_INIT   = 4'd1,
      STEP_OUTER  = 4'd2,
      STEP_RDPAR  = 4'd3,
      STEP_GETPAR = 4'd4,
      STEP_RDKID  = 4'd5,
      STEP_CMP    = 4'd6,
      STEP_NEXT   = 4'd7,
      STEP_SUM    = 4'd8
   } step_type;

   typedef enum logic [2:0] {
      COND_NEXT = 3'd0,   // advance
      COND_JUMP = 3'd1,   // jump unconditionally
      COND_LOAD = 3'd2,   // hold until the last transaction, then jump
      COND_ZERO = 3'd3,   // jump when the node counter is spent
      COND_SIFT = 3'd4,   // swap: jump (or hold on stall); no swap: advance
      COND_EMIT = 3'd5    // hold while the result slot is busy, then jump
   } cond_type;

   typedef struct packed {
      logic     in_ready;
      logic     init_loop;
      logic     next_node;
      logic     cap_parent;
      logic     rd_kids;
      logic     sift;
      logic     emit_sum;
      cond_type cond;
      step_type target;
   } uword_type;

   typedef struct packed {
      logic accept_last;
      logic i_zero;
      logic swap;
      logic stall;
      logic out_busy;
   } seq_stat_type;

   // Control store: one word per step
   function automatic uword_type ucode(input step_type s);
      uword_type w;
      w = '0;
      w.cond   = COND_NEXT;
      w.target = STEP_LOAD;
      unique case (s)
         STEP_LOAD: begin
            w.in_ready = 1'b1;
            w.cond     = COND_LOAD;
            w.target   = STEP_INIT;
         end
         STEP_INIT: begin
            w.init_loop = 1'b1;
         end
         STEP_OUTER: begin
            w.next_node = 1'b1;
            w.cond      = COND_ZERO;
            w.target    = STEP_SUM;
         end
         STEP_RDPAR: begin
            w.cond = COND_NEXT;
         end
         STEP_GETPAR: begin
            w.cap_parent = 1'b1;
         end
         STEP_RDKID: begin
            w.rd_kids = 1'b1;
         end
         STEP_CMP: begin
            w.sift   = 1'b1;
            w.cond   = COND_SIFT;
            w.target = STEP_RDKID;
         end
         STEP_NEXT: begin
            w.cond   = COND_JUMP;
            w.target = STEP_OUTER;
         end
         STEP_SUM: begin
            w.emit_sum = 1'b1;
            w.cond     = COND_EMIT;
            w.target   = STEP_LOAD;
         end
         default: begin
            w.cond   = COND_JUMP;
            w.target = STEP_LOAD;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== sv/mhb_ifs.sv =====
// Valid/ready channel interfaces for the min-heap build block.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface mhb_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] element_value;
   logic               is_last;

   modport source (output valid, element_value, is_last, input ready);
   modport sink   (input valid, element_value, is_last, output ready);
endinterface

interface mhb_rsp_if;
   logic       valid;
   logic       ready;
   logic       item_kind;
   logic [5:0] parent_index;
   logic [5:0] child_index;
   logic [5:0] swap_total;
   logic       overflowed;
   logic       final_flag;

   modport source (output valid, item_kind, parent_index, child_index, swap_total,
                   overflowed, final_flag, input ready);
   modport sink   (input valid, item_kind, parent_index, child_index, swap_total,
                   overflowed, final_flag, output ready);
endinterface

`default_nettype wire

// ===== sv/mhb_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mhb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]         rd_data_a_ff,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_b_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write, then register both read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

// ===== sv/mhb_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on mhb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mhb_seq
   import mhb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire seq_stat_type stat,
   output uword_type         uw
);

   step_type step_ff, step_in;
   step_type step_inc;

   assign step_inc = step_type'(4'(step_ff) + 4'd1);

   // Select the next step from the current word's condition
   always_comb begin
      step_in = step_ff;
      unique case (uw.cond)
         COND_NEXT: step_in = step_inc;
         COND_JUMP: step_in = uw.target;
         COND_LOAD: step_in = stat.accept_last ? uw.target : step_ff;
         COND_ZERO: step_in = stat.i_zero ? uw.target : step_inc;
         COND_SIFT: begin
            priority if (!stat.swap) begin
               step_in = step_inc;
            end else if (stat.stall) begin
               step_in = step_ff;
            end else begin
               step_in = uw.target;
            end
         end
         COND_EMIT: step_in = stat.out_busy ? step_ff : uw.target;
         default:   step_in = STEP_LOAD;
      endcase
   end

   // Drive the control word of the current step
   always_comb begin
      uw = ucode(step_ff);
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/min_heap_build_swaps_unit.sv =====
// Min-heap build block: loads values, builds the heap bottom-up, reports swaps.
// Depends on mhb_pkg, mhb_req_if/mhb_rsp_if, mhb_ram, mhb_seq and assert_macros.svh.
//
// Usage:
//   req_ch carries one signed value per transaction; the transaction with is_last
//   set closes the run. Up to CAPACITY values are stored; later ones are dropped
//   and flagged. rsp_ch then returns one swap record (parent, child) per swap of
//   the sift-down build, in order, followed by one summary (swap count, overflow
//   flag, final_flag set). The store is then empty for the next run.
// Timing:
//   Loading accepts one transaction per cycle. After the last one the build runs
//   on a microcoded loop around the store's two read ports: a setup step, then per
//   internal node (count/2 of them) a parent read and a child read and compare,
//   repeated per swap; then the loop closes and the summary goes out before req_ch is ready again.
// Reset:
//   Synchronous and active high; the store is empty, counters and flags clear.
//   Store contents are not cleared; only loaded entries are ever read.
// Back-pressure:
//   Results pass through one output register; when rsp_ch stalls with a result
//   pending, the sequencer holds on the next swap or summary until it drains.
//   req_ch is not ready during the build.
`timescale 1ns / 1ps
`default_nettype none

module min_heap_build_swaps_unit
   import mhb_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input wire logic  clock,
   input wire logic  reset,
   mhb_req_if.sink   req_ch,
   mhb_rsp_if.source rsp_ch
);

`include "assert_macros.svh"

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int KID_W = CNT_W + 1;

   uword_type    uw;
   seq_stat_type stat;

   // Run state
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [TOTAL_W-1:0]     swaps_ff, swaps_in;
   logic                   drop_ff, drop_in;
   logic [CNT_W-1:0]       iter_ff, iter_in;
   logic [IDX_W-1:0]       node_ff, node_in;
   logic [VALUE_WIDTH-1:0] cur_ff, cur_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   kind_ff, kind_in;
   logic [INDEX_W-1:0]     parent_ff, parent_in;
   logic [INDEX_W-1:0]     child_ff, child_in;
   logic [TOTAL_W-1:0]     total_ff, total_in;
   logic                   ovf_ff, ovf_in;
   logic                   fin_ff, fin_in;

   // Datapath nets
   logic                   accept;
   logic                   has_room;
   logic                   load_wr;
   logic signed [63:0]     wide_value;
   logic [VALUE_WIDTH-1:0] key;
   logic [KID_W-1:0]       left_idx, right_idx;
   logic                   left_ok, right_ok;
   logic [VALUE_WIDTH-1:0] rd_a, rd_b;
   logic                   lt_left, lt_right;
   logic [VALUE_WIDTH-1:0] first_val, best_val;
   logic [IDX_W-1:0]       best_idx;
   logic                   swap;
   logic                   can_emit;
   logic                   out_busy;
   logic                   stall;
   logic                   sift_wr;
   logic                   emit_swap;
   logic                   sum_fire;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [IDX_W-1:0]       rd_addr_a, rd_addr_b;

   // Input side
   assign req_ch.ready = uw.in_ready;
   assign accept       = req_ch.valid && uw.in_ready;
   assign has_room     = count_ff < CNT_W'(CAPACITY);
   assign load_wr      = accept && has_room;
   assign wide_value   = 64'(req_ch.element_value);
   assign key          = wide_value[VALUE_WIDTH-1:0];

   // Child indices of the node being sifted
   assign left_idx  = KID_W'({node_ff, 1'b1});
   assign right_idx = left_idx + KID_W'(1);
   assign left_ok   = left_idx < KID_W'(count_ff);
   assign right_ok  = right_idx < KID_W'(count_ff);

   // Pick the smallest of parent, left and right; ties keep the earlier one
   assign lt_left   = left_ok && ($signed(rd_a) < $signed(cur_ff));
   assign first_val = lt_left ? rd_a : cur_ff;
   assign lt_right  = right_ok && ($signed(rd_b) < $signed(first_val));
   assign best_val  = lt_right ? rd_b : first_val;
   assign best_idx  = lt_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
   assign swap      = lt_left || lt_right;

   // Emission and back-pressure
   assign out_busy  = rsp_valid_ff && !rsp_ch.ready;
   assign can_emit  = swaps_ff != SWAP_MAX;
   assign stall     = uw.sift && swap && can_emit && out_busy;
   assign sift_wr   = uw.sift && !stall;
   assign emit_swap = sift_wr && swap && can_emit;
   assign sum_fire  = uw.emit_sum && !out_busy;

   // Store port selection; keep the children addressed while the compare holds
   assign wr_en     = load_wr || sift_wr;
   assign wr_addr   = load_wr ? count_ff[IDX_W-1:0] : node_ff;
   assign wr_data   = load_wr ? key : (swap ? best_val : cur_ff);
   assign rd_addr_a = (uw.rd_kids || uw.sift) ? left_idx[IDX_W-1:0] : node_ff;
   assign rd_addr_b = right_idx[IDX_W-1:0];

   mhb_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr_a    (rd_addr_a),
      .rd_data_a_ff (rd_a),
      .rd_addr_b    (rd_addr_b),
      .rd_data_b_ff (rd_b)
   );

   // Sequencer status
   always_comb begin
      stat.accept_last = accept && req_ch.is_last;
      stat.i_zero      = iter_ff == '0;
      stat.swap        = swap;
      stat.stall       = stall;
      stat.out_busy    = out_busy;
   end

   mhb_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .uw    (uw)
   );

   // Run state next values
   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      swaps_in = swaps_ff;
      iter_in  = iter_ff;
      node_in  = node_ff;
      cur_in   = cur_ff;
      if (load_wr) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (accept && !has_room) begin
         drop_in = 1'b1;
      end
      if (uw.init_loop) begin
         iter_in = count_ff >> 1;
      end
      if (uw.next_node && iter_ff != '0) begin
         iter_in = iter_ff - CNT_W'(1);
         node_in = IDX_W'(iter_ff - CNT_W'(1));
      end
      if (uw.cap_parent) begin
         cur_in = rd_a;
      end
      if (sift_wr && swap) begin
         node_in = best_idx;
      end
      if (emit_swap) begin
         swaps_in = swaps_ff + TOTAL_W'(1);
      end
      if (sum_fire) begin
         count_in = '0;
         swaps_in = '0;
         drop_in  = 1'b0;
      end
   end

   // Result register next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      kind_in      = kind_ff;
      parent_in    = parent_ff;
      child_in     = child_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      fin_in       = fin_ff;
      priority if (emit_swap) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_SWAP;
         parent_in    = INDEX_W'(node_ff);
         child_in     = INDEX_W'(best_idx);
         total_in     = '0;
         ovf_in       = 1'b0;
         fin_in       = 1'b0;
      end else if (sum_fire) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_SUMMARY;
         parent_in    = '0;
         child_in     = '0;
         total_in     = swaps_ff;
         ovf_in       = drop_ff;
         fin_in       = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         swaps_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         swaps_ff     <= swaps_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      iter_ff   <= iter_in;
      node_ff   <= node_in;
      cur_ff    <= cur_in;
      kind_ff   <= kind_in;
      parent_ff <= parent_in;
      child_ff  <= child_in;
      total_ff  <= total_in;
      ovf_ff    <= ovf_in;
      fin_ff    <= fin_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.item_kind    = kind_ff;
   assign rsp_ch.parent_index = parent_ff;
   assign rsp_ch.child_index  = child_ff;
   assign rsp_ch.swap_total   = total_ff;
   assign rsp_ch.overflowed   = ovf_ff;
   assign rsp_ch.final_flag   = fin_ff;

   // Checks
   `MHB_ASSERT(a_count_cap, count_ff <= CNT_W'(CAPACITY), "element count beyond capacity")
   `MHB_IMPLY(a_node_loaded, uw.sift, CNT_W'(node_ff) < count_ff, "sift node not loaded")
   `MHB_IMPLY(a_child_of_parent, rsp_valid_ff && kind_ff == KIND_SWAP, (7'(child_ff) == 7'(parent_ff) * 7'd2 + 7'd1) || (7'(child_ff) == 7'(parent_ff) * 7'd2 + 7'd2), "swap record child is not a child of parent")
   `MHB_NEXT(a_sum_clears, sum_fire, count_ff == '0 && swaps_ff == '0 && !drop_ff, "run state not cleared after summary")

endmodule

`default_nettype wire

// ===== test/min_heap_build_swaps_check.sv =====
// Checker for the min-heap build block: watches both channels, predicts the swap
// records and the summary of each run, and compares every result transaction.
// Depends on mhb_pkg and the mhb_req_if / mhb_rsp_if interfaces.
`timescale 1ns / 1ps

module min_heap_build_swaps_check
   import mhb_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   mhb_req_if   req_mon,
   mhb_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   swap_count,
   output int   summary_count,
   output int   drop_count
);

   localparam int STORE_DEPTH = 64;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] parent;
      logic [INDEX_W-1:0] child;
      logic [TOTAL_W-1:0] total;
      logic               ovf;
      logic               fin;
   } heap_result_type;

   // Own copy of the block's store and run state
   longint          heap_keys [STORE_DEPTH];
   int              fill_level;
   bit              dropped_any;
   heap_result_type expected_q [$];
   int              mismatches;
   int              swaps_done;
   int              summaries_done;
   int              drops_done;

   // Sign-extend the 32-bit field and wrap it to the store width
   function automatic longint widen_key(input logic signed [31:0] v);
      longint k;
      k = longint'(v);
      if (VALUE_WIDTH < 64) k = (k <<< (64 - VALUE_WIDTH)) >>> (64 - VALUE_WIDTH);
      return k;
   endfunction

   // Sift every internal node down and queue one record per swap, then the summary
   task automatic predict_build();
      int              n;
      int              node;
      int              best;
      int              lc;
      int              rc;
      int              swaps;
      bit              settled;
      longint          tmp;
      heap_result_type r;
      n     = fill_level;
      swaps = 0;
      for (int i = n / 2; i > 0; i--) begin
         node    = i - 1;
         settled = 1'b0;
         while (!settled) begin
            best = node;
            lc   = 2 * node + 1;
            rc   = 2 * node + 2;
            if (lc < n && heap_keys[lc] < heap_keys[best]) best = lc;
            if (rc < n && heap_keys[rc] < heap_keys[best]) best = rc;
            if (best == node) begin
               settled = 1'b1;
            end else begin
               tmp             = heap_keys[node];
               heap_keys[node] = heap_keys[best];
               heap_keys[best] = tmp;
               // swaps past the counter limit still happen but are not reported
               if (swaps < int'(SWAP_MAX)) begin
                  r          = '0;
                  r.kind     = KIND_SWAP;
                  r.parent   = node[INDEX_W-1:0];
                  r.child    = best[INDEX_W-1:0];
                  expected_q = {expected_q, r};
                  swaps++;
               end
               node = best;
            end
         end
      end
      r           = '0;
      r.kind      = KIND_SUMMARY;
      r.total     = swaps[TOTAL_W-1:0];
      r.ovf       = dropped_any;
      r.fin       = 1'b1;
      expected_q  = {expected_q, r};
      fill_level  = 0;
      dropped_any = 1'b0;
   endtask

   // Store one element, or drop it when full; the last one starts the build
   task automatic absorb_element(input logic signed [31:0] v, input logic last);
      if (fill_level < CAPACITY && fill_level < STORE_DEPTH) begin
         heap_keys[fill_level] = widen_key(v);
         fill_level++;
      end else begin
         dropped_any = 1'b1;
         drops_done++;
      end
      if (last) predict_build();
   endtask

   // Compare one result transaction with the oldest expectation
   task automatic check_result();
      heap_result_type got;
      heap_result_type want;
      got.kind   = rsp_mon.item_kind;
      got.parent = rsp_mon.parent_index;
      got.child  = rsp_mon.child_index;
      got.total  = rsp_mon.swap_total;
      got.ovf    = rsp_mon.overflowed;
      got.fin    = rsp_mon.final_flag;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("%0t: result with nothing expected: kind=%0d parent=%0d child=%0d",
                     $realtime, got.kind, got.parent, got.child);
         return;
      end
      want = expected_q.pop_front();
      if (want.kind == KIND_SUMMARY) summaries_done++;
      else swaps_done++;
      if (got.kind !== want.kind || got.parent !== want.parent || got.child !== want.child
          || got.total !== want.total || got.ovf !== want.ovf || got.fin !== want.fin) begin
         mismatches++;
         if (mismatches <= REPORT_MAX) begin
            $display("%0t: mismatch, expected kind=%0d parent=%0d child=%0d total=%0d ovf=%0d fin=%0d",
                     $realtime, want.kind, want.parent, want.child, want.total, want.ovf,
                     want.fin);
            $display("%0t:           got kind=%0d parent=%0d child=%0d total=%0d ovf=%0d fin=%0d",
                     $realtime, got.kind, got.parent, got.child, got.total, got.ovf,
                     got.fin);
         end
      end
   endtask

   // Check results before predicting, so a new run never pairs with an old result
   always @(posedge clock) begin
      if (reset) begin
         fill_level     = 0;
         dropped_any    = 1'b0;
         mismatches     = 0;
         swaps_done     = 0;
         summaries_done = 0;
         drops_done     = 0;
         expected_q.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) check_result();
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            absorb_element(req_mon.element_value, req_mon.is_last);
      end
      fail_count    <= mismatches;
      pending_count <= expected_q.size();
      swap_count    <= swaps_done;
      summary_count <= summaries_done;
      drop_count    <= drops_done;
   end

endmodule

// ===== test/min_heap_build_swaps_unit_test.sv =====
// Testbench top for the min-heap build block: clock, reset, element stimulus,
// result back-pressure, watchdog and verdict. Depends on mhb_pkg, the channel
// interfaces, min_heap_build_swaps_unit and min_heap_build_swaps_check.
`timescale 1ns / 1ps

module min_heap_build_swaps_unit_test;
   import mhb_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int ITEM_TARGET = 260;
   localparam int CALM_FROM   = 225;
   localparam int SQUEEZE_LEN = 600;
   // Long enough for a full build of a full store; allow for the long hold-off too
   localparam int QUIET_LIMIT = 6000;
   localparam int DRAIN_WAIT  = 20;

   localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;

   typedef enum int {SHAPE_SPREAD, SHAPE_NARROW, SHAPE_FALLING, SHAPE_EDGES} value_shape_type;

   logic clock = 1'b0;
   logic reset;
   bit   calm;
   bit   squeeze_req;
   int   items_sent;
   int   fail_count;
   int   pending_count;
   int   swap_count;
   int   summary_count;
   int   drop_count;
   logic signed [31:0] run_q [$];

   mhb_req_if req_ch ();
   mhb_rsp_if rsp_ch ();

   min_heap_build_swaps_unit #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   min_heap_build_swaps_check #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .swap_count    (swap_count),
      .summary_count (summary_count),
      .drop_count    (drop_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Offer one element, with an occasional gap before it, and hold until accepted
   task automatic offer(input logic signed [31:0] v, input logic last);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.element_value <= v;
      req_ch.is_last       <= last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      items_sent++;
      if (items_sent >= CALM_FROM) calm <= 1'b1;
   endtask

   // Send the staged values as one run, the last one closing it
   task automatic send_run();
      for (int k = 0; k < run_q.size(); k++) offer(run_q[k], k == run_q.size() - 1);
   endtask

   function automatic logic signed [31:0] pick_value(input value_shape_type shape, input int k);
      int t;
      case (shape)
         SHAPE_NARROW: begin
            // few distinct values, so ties between children and parents are common
            t = int'($urandom_range(0, 6)) - 3;
            return t;
         end
         SHAPE_FALLING: begin
            // mostly falling input, which forces many swaps
            t = 2000000000 - k * int'($urandom_range(1, 5000));
            return t;
         end
         SHAPE_EDGES: begin
            case ($urandom_range(0, 3))
               0:       return MOST_NEG;
               1:       return MOST_POS;
               2:       return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic stage_random(input int len, input value_shape_type shape);
      run_q.delete();
      for (int k = 0; k < len; k++) run_q = {run_q, pick_value(shape, k)};
   endtask

   // Result side: random ready bursts, one long hold-off on request, none at the end
   initial begin : receiver
      bit squeeze_done;
      squeeze_done  = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (squeeze_req && !squeeze_done) begin
            squeeze_done  = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (SQUEEZE_LEN) @(posedge clock);
         end else if (calm) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge clock);
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   // End the run when nothing has moved on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
             || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int len;
      reset                <= 1'b1;
      calm                 <= 1'b0;
      squeeze_req          <= 1'b0;
      req_ch.valid         <= 1'b0;
      req_ch.element_value <= '0;
      req_ch.is_last       <= 1'b0;
      items_sent            = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: single element, extremes, ties, multi-level sifts
      run_q = '{MOST_NEG};
      send_run();
      run_q = '{MOST_POS, MOST_NEG};
      send_run();
      // equal children: the left one wins
      run_q = '{32'sd5, 32'sd3, 32'sd3};
      send_run();
      // child equal to parent: no swap
      run_q = '{32'sd3, 32'sd3, 32'sd5};
      send_run();
      run_q = '{32'sd6, 32'sd5, 32'sd4, 32'sd3, 32'sd2, 32'sd1, 32'sd0};
      send_run();
      run_q = '{MOST_POS, MOST_NEG, 32'sd0, -32'sd1, 32'sd1};
      send_run();

      // Store exactly full with falling values, under a long result hold-off
      squeeze_req <= 1'b1;
      stage_random(CAPACITY, SHAPE_FALLING);
      send_run();
      // Overrun the store; the closing element itself is dropped
      stage_random(CAPACITY + 3, SHAPE_SPREAD);
      send_run();

      // Random runs, mostly short
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) len = $urandom_range(13, 40);
         else len = $urandom_range(1, 12);
         stage_random(len, value_shape_type'($urandom_range(0, 3)));
         send_run();
      end
      req_ch.valid <= 1'b0;

      // Let the checker count the last run, drain, then allow for any stray result
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d elements (%0d dropped at capacity); checked %0d swap records",
               items_sent, drop_count, swap_count);
      $display("and %0d run summaries, with %0d results still outstanding",
               summary_count, pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
